// ===== hw/rtl/pket_pkg.sv =====
package pket_pkg;
  localparam int PairEntriesDef  = 256;
  localparam int EventEntriesDef = 64;
  localparam int UserEntriesDef  = 64;
  localparam int IdBitsDef       = 16;

  localparam logic [2:0] StSuppressed = 3'd0;
  localparam logic [2:0] StAccepted   = 3'd1;
  localparam logic [2:0] StPairFull   = 3'd2;
  localparam logic [2:0] StEventFull  = 3'd3;
  localparam logic [2:0] StUserFull   = 3'd4;

  typedef struct packed {
    logic [31:0] timestamp;
    logic [15:0] user_id;
    logic [15:0] event_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] total_accepted;
    logic [31:0] event_tally_out;
    logic [31:0] user_tally_out;
  } rsp_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction
endpackage

// ===== hw/rtl/per_key_event_throttle_counter.sv =====
// Per-key event throttle. Pulse start with an event while busy is low;
// exactly one result appears for one cycle with done_o high, and it cannot be
// held off. busy stays high while the tables are scanned up to N entries and
// while the decision is made, where N is the largest of the pair, event and
// user entries in use. The result shows in the last busy cycle, and the next
// request can be taken as soon as busy drops. The three tables are scanned one
// entry per cycle through their single read ports; on an accepted event each
// table's matched or new entry is then written. min_interval is written
// through cfg_valid_i/cfg_ready_o while the block is idle.
module per_key_event_throttle_counter
  import pket_pkg::*;
#(
  parameter int PAIR_ENTRIES  = PairEntriesDef,
  parameter int EVENT_ENTRIES = EventEntriesDef,
  parameter int USER_ENTRIES  = UserEntriesDef,
  parameter int ID_BITS       = IdBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i
);
  localparam int PA = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
  localparam int EA = (EVENT_ENTRIES > 1) ? $clog2(EVENT_ENTRIES) : 1;
  localparam int UA = (USER_ENTRIES > 1) ? $clog2(USER_ENTRIES) : 1;
  localparam int PC = $clog2(PAIR_ENTRIES + 1);
  localparam int EC = $clog2(EVENT_ENTRIES + 1);
  localparam int UC = $clog2(USER_ENTRIES + 1);
  localparam int SW = (PC > EC) ? ((PC > UC) ? PC : UC) : ((EC > UC) ? EC : UC);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic [30:0] min_q;
  logic [PC-1:0] pused_q;
  logic [EC-1:0] eused_q;
  logic [UC-1:0] uused_q;
  logic [31:0] total_q;
  logic [31:0] ts_q;
  logic [ID_BITS-1:0] uid_q, eid_q;
  logic [SW-1:0] idx_q;       // address issued
  logic          rv_q;        // read data valid this cycle
  logic [SW-1:0] ridx_q;      // index of data returning
  logic hp_q, he_q, hu_q;
  logic [PA-1:0] p_q;
  logic [EA-1:0] e_q;
  logic [UA-1:0] u_q;
  logic [31:0] ptime_q, etal_q, utal_q;
  rsp_t rsp_q;

  logic [2*ID_BITS+31:0] pr_d;
  logic [ID_BITS+31:0] er_d, ur_d;
  logic pwe, ewe, uwe;
  logic [PA-1:0] pwa;
  logic [EA-1:0] ewa;
  logic [UA-1:0] uwa;
  logic [2*ID_BITS+31:0] pwd;
  logic [ID_BITS+31:0] ewd, uwd;

  logic [SW-1:0] scan_n;
  assign scan_n = (SW'(pused_q) > SW'(eused_q)) ?
                  ((SW'(pused_q) > SW'(uused_q)) ? SW'(pused_q) : SW'(uused_q)) :
                  ((SW'(eused_q) > SW'(uused_q)) ? SW'(eused_q) : SW'(uused_q));

  pket_ram #(.Width(2*ID_BITS+32), .Depth(PAIR_ENTRIES)) u_pair (
    .clk_i, .we_i(pwe), .waddr_i(pwa), .wdata_i(pwd),
    .raddr_i(idx_q[PA-1:0]), .rdata_o(pr_d));
  pket_ram #(.Width(ID_BITS+32), .Depth(EVENT_ENTRIES)) u_evt (
    .clk_i, .we_i(ewe), .waddr_i(ewa), .wdata_i(ewd),
    .raddr_i(idx_q[EA-1:0]), .rdata_o(er_d));
  pket_ram #(.Width(ID_BITS+32), .Depth(USER_ENTRIES)) u_usr (
    .clk_i, .we_i(uwe), .waddr_i(uwa), .wdata_i(uwd),
    .raddr_i(idx_q[UA-1:0]), .rdata_o(ur_d));

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign rsp_o       = rsp_q;

  // decision
  logic signed [32:0] diff;
  logic accept;
  logic [2:0] status;
  assign diff   = $signed({1'b0, ts_q}) - $signed({1'b0, ptime_q});
  assign accept = !hp_q || (diff >= $signed({2'b0, min_q}));
  always_comb begin
    if (!accept) status = StSuppressed;
    else if (!hp_q && pused_q >= PC'(PAIR_ENTRIES)) status = StPairFull;
    else if (!he_q && eused_q >= EC'(EVENT_ENTRIES)) status = StEventFull;
    else if (!hu_q && uused_q >= UC'(USER_ENTRIES)) status = StUserFull;
    else status = StAccepted;
  end
  logic ok;
  assign ok = (state_q == S_DEC) && (status == StAccepted);
  logic [31:0] etn, utn;
  assign etn = sat_inc(he_q ? etal_q : 32'd0);
  assign utn = sat_inc(hu_q ? utal_q : 32'd0);

  assign pwe = ok;
  assign pwa = hp_q ? p_q : pused_q[PA-1:0];
  assign pwd = {uid_q, eid_q, ts_q};
  assign ewe = ok;
  assign ewa = he_q ? e_q : eused_q[EA-1:0];
  assign ewd = {eid_q, etn};
  assign uwe = ok;
  assign uwa = hu_q ? u_q : uused_q[UA-1:0];
  assign uwd = {uid_q, utn};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_SCAN;
      S_SCAN: if (!rv_q && idx_q >= scan_n) state_d = S_DEC;
      S_DEC:  state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      min_q   <= '0;
      pused_q <= '0;
      eused_q <= '0;
      uused_q <= '0;
      total_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) min_q <= cfg_data_i;
      rv_q <= (state_q == S_SCAN) && (idx_q < scan_n);
      if (ok) begin
        total_q <= sat_inc(total_q);
        if (!hp_q) pused_q <= pused_q + PC'(1);
        if (!he_q) eused_q <= eused_q + EC'(1);
        if (!hu_q) uused_q <= uused_q + UC'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      ts_q  <= req_i.timestamp;
      uid_q <= req_i.user_id[ID_BITS-1:0];
      eid_q <= req_i.event_id[ID_BITS-1:0];
      idx_q <= '0;
      hp_q  <= 1'b0;
      he_q  <= 1'b0;
      hu_q  <= 1'b0;
    end else if (state_q == S_SCAN) begin
      if (idx_q < scan_n) idx_q <= idx_q + SW'(1);
      ridx_q <= idx_q;
      // first match wins per table
      if (rv_q) begin
        if (!hp_q && ridx_q < SW'(pused_q) &&
            pr_d[2*ID_BITS+31:ID_BITS+32] == uid_q &&
            pr_d[ID_BITS+31:32] == eid_q) begin
          hp_q <= 1'b1;
          p_q <= ridx_q[PA-1:0];
          ptime_q <= pr_d[31:0];
        end
        if (!he_q && ridx_q < SW'(eused_q) && er_d[ID_BITS+31:32] == eid_q) begin
          he_q <= 1'b1;
          e_q <= ridx_q[EA-1:0];
          etal_q <= er_d[31:0];
        end
        if (!hu_q && ridx_q < SW'(uused_q) && ur_d[ID_BITS+31:32] == uid_q) begin
          hu_q <= 1'b1;
          u_q <= ridx_q[UA-1:0];
          utal_q <= ur_d[31:0];
        end
      end
    end else if (state_q == S_DEC) begin
      rsp_q.status <= status;
      if (ok) begin
        rsp_q.total_accepted  <= sat_inc(total_q);
        rsp_q.event_tally_out <= etn;
        rsp_q.user_tally_out  <= utn;
      end else begin
        rsp_q.total_accepted  <= total_q;
        rsp_q.event_tally_out <= he_q ? etal_q : 32'd0;
        rsp_q.user_tally_out  <= hu_q ? utal_q : 32'd0;
      end
    end
  end
endmodule

// ===== hw/rtl/pket_ram.sv =====
module pket_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/pket_checker.sv =====
module pket_checker
  import pket_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o,
  input logic cfg_ready_o
);
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held more than one cycle");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result while idle");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.status <= StUserFull) else $error("bad status");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !busy) else $error("config ready while busy");
endmodule

bind per_key_event_throttle_counter pket_checker u_pket_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o, .cfg_ready_o);
